// ===== rtl/core/av1_sequence_header_locator_top_assert.svh =====
// Assertion macros used by the sequence header locator parser.
`ifndef AV1_SEQUENCE_HEADER_LOCATOR_TOP_ASSERT_SVH
`define AV1_SEQUENCE_HEADER_LOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define AVSH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define AVSH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AVSH_ASSERT(lbl, clk, rst_n, prop)
`define AVSH_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/avsh_pkg.sv =====
// Shared types and constants of the AV1 sequence header locator.
package avsh_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int HDR_OFFSET_W      = 24;
  localparam int HDR_LENGTH_W      = 25;
  localparam int OUT_TDATA_W       = 56;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_FORBIDDEN  = 3'd2,
    ST_TRUNCATED  = 3'd3,
    ST_LEB_LONG   = 3'd4,
    ST_SIZELESS   = 3'd5,
    ST_TOO_LONG   = 3'd6
  } status_t;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } beat_t;

  // Packed so that status lands in the low bits of tdata.
  typedef struct packed {
    logic [HDR_LENGTH_W-1:0] header_length;
    logic [HDR_OFFSET_W-1:0] header_offset;
    status_t                 status;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t res;
  } res_push_t;

endpackage

// ===== rtl/core/avsh_in_stage.sv =====
// Input register: holds one byte beat until the parser takes it.
module avsh_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  avsh_pkg::beat_t in_beat,
  input  logic           take,
  output logic           item_valid,
  output avsh_pkg::beat_t item
);

  logic            v_r;
  avsh_pkg::beat_t beat_r;

  assign in_tready  = !v_r || take;
  assign item_valid = v_r;
  assign item       = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      v_r <= 1'b1;
    end else if (take) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      beat_r <= in_beat;
    end
  end

endmodule

// ===== rtl/core/avsh_parser.sv =====
// OBU walker: per-byte state update and result decision.
module avsh_parser #(
  parameter int POSITION_BITS = avsh_pkg::POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  avsh_pkg::beat_t      item,
  output avsh_pkg::res_push_t  push
);

  `include "av1_sequence_header_locator_top_assert.svh"

  localparam int PB = POSITION_BITS;
  localparam logic [PB+1:0] LIMIT = (PB+2)'(1) << PB;
  localparam logic [3:0] OBU_SEQ_HDR = 4'd1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_EXT,
    PH_LEB,
    PH_PAYLOAD,
    PH_TAIL
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [PB:0]   pos_r, pos_nxt;
  logic [PB-1:0] start_r, start_nxt;
  logic          is_seq_r, is_seq_nxt;
  logic          has_size_r, has_size_nxt;
  logic [PB:0]   acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;
  logic [3:0]    leb_cnt_r, leb_cnt_nxt;
  logic [PB:0]   left_r, left_nxt;
  logic          decided_r, decided_nxt;

  logic                  emit;
  avsh_pkg::status_t     st;
  logic [PB-1:0]         found_off;
  logic [PB:0]           found_len;
  logic [63:0]           off_w, len_w;

  // leb128 piece, shifted into place
  logic [5:0]  shamt;
  logic [62:0] part;
  logic        part_hi;
  logic [PB+1:0] acc_sum;
  logic [PB+1:0] end_sum;

  assign shamt   = 6'(leb_cnt_r[2:0]) * 6'd7;
  assign part    = 63'(item.data_byte[6:0]) << shamt;
  assign part_hi = |part[62:PB+1];
  assign acc_sum = {1'b0, acc_r} + {1'b0, part[PB:0]};

  always_comb begin
    logic          seq_v;
    logic          size_v;
    logic [PB-1:0] start_v;
    logic [PB:0]   left_v;
    logic          fin;
    logic          pre;
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    is_seq_nxt   = is_seq_r;
    has_size_nxt = has_size_r;
    acc_nxt      = acc_r;
    ovf_nxt      = ovf_r;
    leb_cnt_nxt  = leb_cnt_r;
    left_nxt     = left_r;
    decided_nxt  = decided_r;
    emit         = 1'b0;
    st           = avsh_pkg::ST_NOT_FOUND;
    seq_v        = is_seq_r;
    size_v       = has_size_r;
    start_v      = start_r;
    left_v       = left_r;
    fin          = 1'b0;
    pre          = 1'b0;
    end_sum      = '0;

    if (!decided_r) begin
      if (pos_r[PB]) begin
        emit = 1'b1;
        st   = avsh_pkg::ST_TOO_LONG;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            start_v   = pos_r[PB-1:0];
            start_nxt = start_v;
            if (item.data_byte[7]) begin
              emit = 1'b1;
              st   = avsh_pkg::ST_FORBIDDEN;
            end else begin
              seq_v        = (item.data_byte[6:3] == OBU_SEQ_HDR);
              size_v       = item.data_byte[1];
              is_seq_nxt   = seq_v;
              has_size_nxt = size_v;
              if (item.data_byte[2]) begin
                if (item.last_byte) begin
                  emit = 1'b1;
                  st   = avsh_pkg::ST_TRUNCATED;
                end else begin
                  phase_nxt = PH_EXT;
                end
              end else begin
                pre = 1'b1;
              end
            end
          end
          PH_EXT: begin
            pre = 1'b1;
          end
          PH_LEB: begin
            if (!ovf_r) begin
              if (part_hi || acc_sum > LIMIT) begin
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = acc_sum[PB:0];
              end
            end
            leb_cnt_nxt = leb_cnt_r + 4'd1;
            end_sum = (PB+2)'(pos_r) + (PB+2)'(1) + (PB+2)'(acc_nxt);
            if (item.data_byte[7]) begin
              if (item.last_byte) begin
                emit = 1'b1;
                st   = avsh_pkg::ST_TRUNCATED;
              end else if (leb_cnt_nxt >= 4'd8) begin
                emit = 1'b1;
                st   = avsh_pkg::ST_LEB_LONG;
              end
            end else if (ovf_nxt || end_sum > LIMIT) begin
              emit = 1'b1;
              st   = avsh_pkg::ST_TRUNCATED;
            end else begin
              left_nxt = acc_nxt;
              if (acc_nxt == '0) begin
                fin = 1'b1;
              end else if (item.last_byte) begin
                emit = 1'b1;
                st   = avsh_pkg::ST_TRUNCATED;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            left_v   = left_r - (PB+1)'(left_r != '0);
            left_nxt = left_v;
            if (left_v == '0) begin
              fin = 1'b1;
            end else if (item.last_byte) begin
              emit = 1'b1;
              st   = avsh_pkg::ST_TRUNCATED;
            end
          end
          PH_TAIL: begin
            if (item.last_byte) begin
              emit = 1'b1;
              st   = avsh_pkg::ST_FOUND;
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase

        // header prefix complete
        if (pre) begin
          if (!size_v) begin
            if (!seq_v) begin
              emit = 1'b1;
              st   = avsh_pkg::ST_SIZELESS;
            end else if (item.last_byte) begin
              emit = 1'b1;
              st   = avsh_pkg::ST_FOUND;
            end else begin
              phase_nxt = PH_TAIL;
            end
          end else if (item.last_byte) begin
            emit = 1'b1;
            st   = avsh_pkg::ST_TRUNCATED;
          end else begin
            phase_nxt   = PH_LEB;
            acc_nxt     = '0;
            ovf_nxt     = 1'b0;
            leb_cnt_nxt = '0;
          end
        end

        // OBU complete
        if (fin) begin
          if (is_seq_r) begin
            emit = 1'b1;
            st   = avsh_pkg::ST_FOUND;
          end else if (item.last_byte) begin
            emit = 1'b1;
            st   = avsh_pkg::ST_NOT_FOUND;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
      end
    end

    if (emit) begin
      decided_nxt = 1'b1;
    end

    found_off = start_v;
    found_len = pos_r + (PB+1)'(1) - (PB+1)'(start_v);

    if (item.last_byte) begin
      phase_nxt    = PH_HEADER;
      pos_nxt      = '0;
      start_nxt    = '0;
      is_seq_nxt   = 1'b0;
      has_size_nxt = 1'b0;
      acc_nxt      = '0;
      ovf_nxt      = 1'b0;
      leb_cnt_nxt  = '0;
      left_nxt     = '0;
      decided_nxt  = 1'b0;
    end else if (!pos_r[PB]) begin
      pos_nxt = pos_r + (PB+1)'(1);
    end
  end

  assign off_w = (st == avsh_pkg::ST_FOUND) ? 64'(found_off) : 64'd0;
  assign len_w = (st == avsh_pkg::ST_FOUND) ? 64'(found_len) : 64'd0;

  assign push.load              = go && emit;
  assign push.res.status        = st;
  assign push.res.header_offset = off_w[avsh_pkg::HDR_OFFSET_W-1:0];
  assign push.res.header_length = len_w[avsh_pkg::HDR_LENGTH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      start_r    <= '0;
      is_seq_r   <= 1'b0;
      has_size_r <= 1'b0;
      acc_r      <= '0;
      ovf_r      <= 1'b0;
      leb_cnt_r  <= '0;
      left_r     <= '0;
      decided_r  <= 1'b0;
    end else if (go) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      is_seq_r   <= is_seq_nxt;
      has_size_r <= has_size_nxt;
      acc_r      <= acc_nxt;
      ovf_r      <= ovf_nxt;
      leb_cnt_r  <= leb_cnt_nxt;
      left_r     <= left_nxt;
      decided_r  <= decided_nxt;
    end
  end

  `AVSH_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (pos_r == '0 && !decided_r && phase_r == PH_HEADER))
  `AVSH_ASSERT(a_one_result, clk, rst_n, push.load |-> !decided_r)
  `AVSH_ASSERT(a_found_len, clk, rst_n, (push.load && st == avsh_pkg::ST_FOUND) |-> found_len != '0)
  `AVSH_ASSERT(a_last_rearms, clk, rst_n, (go && item.last_byte) |=> (pos_r == '0 && !decided_r))

endmodule

// ===== rtl/core/avsh_out_stage.sv =====
// Result register: holds one result beat until the receiver takes it.
module avsh_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  avsh_pkg::res_push_t              push,
  output logic                             space,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [avsh_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int RES_W = $bits(avsh_pkg::result_t);

  logic              v_r;
  avsh_pkg::result_t res_r;

  assign space      = !v_r || out_tready;
  assign out_tvalid = v_r;
  assign out_tdata  = {{(avsh_pkg::OUT_TDATA_W-RES_W){1'b0}}, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (push.load) begin
      v_r <= 1'b1;
    end else if (out_tready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.load) begin
      res_r <= push.res;
    end
  end

endmodule

// ===== rtl/core/av1_sequence_header_locator_top.sv =====
// Top level of the AV1 sequence header locator.
//
// Input stream: one packet byte per beat, in_tdata[7:0], in_tlast marks the
// last byte of the packet. The block walks the OBU headers and finds the
// first sequence header OBU. Exactly one result beat leaves per packet.
// Output stream: out_tdata carries status, header offset and header length.
// Throughput: one byte per cycle, sustained, while out_tready allows it.
// A byte accepted into the input register is parsed once the result register
// can take a beat; a result it causes is loaded there and shown on out_tvalid.
// The per-byte parser is a single registered state update; its leb128 size
// add and end-of-payload compare set the clock path.
// Reset (rst_n low, synchronous) empties both registers and rearms the
// parser for the start of a packet.
// Receiver stall: the result register holds its beat; the input register
// keeps one byte and in_tready drops once both are full. Nothing is lost.
// Packets larger than 2^POSITION_BITS bytes report status too long, unless decided earlier.
module av1_sequence_header_locator_top #(
  parameter int POSITION_BITS = avsh_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // slave side: tdata[7:0] data_byte; tlast = last_byte
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  input  logic                             in_tlast,
  // master side: tdata[2:0] status, [26:3] header_offset,
  // [51:27] header_length, [55:52] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [avsh_pkg::OUT_TDATA_W-1:0] out_tdata
);

  avsh_pkg::beat_t     in_beat;
  avsh_pkg::beat_t     item;
  avsh_pkg::res_push_t push;
  logic                item_valid;
  logic                space;
  logic                go;

  assign in_beat.data_byte = in_tdata;
  assign in_beat.last_byte = in_tlast;

  // parse a held byte whenever the result register can take its beat
  assign go = item_valid && space;

  avsh_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_beat    (in_beat),
    .take       (go),
    .item_valid (item_valid),
    .item       (item)
  );

  avsh_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item),
    .push  (push)
  );

  avsh_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/tb_av1_sequence_header_locator_top.sv =====
// Self-checking testbench for the AV1 sequence header locator top level.
module tb_av1_sequence_header_locator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF      = 10;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned BYTE_TARGET   = 1250;
  // Spare edges after the drain catch stray result beats.
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam longint unsigned PACKET_LIMIT = 64'd1 << avsh_pkg::POSITION_BITS_DEF;
  localparam int unsigned OUT_W         = avsh_pkg::OUT_TDATA_W;

  // OBU header byte: [7] forbidden, [6:3] type, [2] extension, [1] has-size,
  // [0] reserved. leb128 bytes carry 7 size bits plus a continuation flag.
  localparam int unsigned FORBID_BIT    = 7;
  localparam int unsigned LEB_CONT_BIT  = 7;
  localparam int unsigned LEB_MAX_BYTES = 8;
  localparam logic [3:0] OBU_SEQ_HDR    = 4'd1;
  localparam logic [3:0] OBU_TEMP_DELIM = 4'd2;

  typedef enum logic [2:0] {
    WALK_HEADER, WALK_EXT, WALK_SIZE, WALK_PAYLOAD, WALK_TAIL
  } walk_t;

  // Tracks the OBU walk of the current packet and holds the result each
  // packet should produce, in packet order.
  class header_search_scoreboard;
    avsh_pkg::result_t expected_q[$];
    int unsigned mismatches;

    walk_t           walk;
    longint unsigned byte_pos;
    longint unsigned obu_start;
    longint unsigned size_acc;
    longint unsigned payload_left;
    int unsigned     leb_count;
    bit              obu_is_seq;
    bit              obu_sized;
    bit              size_bad;
    bit              decided;

    function new();
      mismatches = 0;
      rearm();
    endfunction

    function void rearm();
      walk         = WALK_HEADER;
      byte_pos     = 0;
      obu_start    = 0;
      size_acc     = 0;
      payload_left = 0;
      leb_count    = 0;
      obu_is_seq   = 1'b0;
      obu_sized    = 1'b0;
      size_bad     = 1'b0;
      decided      = 1'b0;
    endfunction

    function void post_status(avsh_pkg::status_t st, longint unsigned off,
                              longint unsigned len);
      avsh_pkg::result_t r;
      r.status        = st;
      r.header_offset = off[avsh_pkg::HDR_OFFSET_W-1:0];
      r.header_length = len[avsh_pkg::HDR_LENGTH_W-1:0];
      expected_q.push_back(r);
      decided = 1'b1;
    endfunction

    function void post_found(longint unsigned p);
      post_status(avsh_pkg::ST_FOUND, obu_start, p + 1 - obu_start);
    endfunction

    // Header and optional extension byte are done.
    function void prefix_end(longint unsigned p, bit last);
      if (!obu_sized) begin
        if (!obu_is_seq) post_status(avsh_pkg::ST_SIZELESS, 0, 0);
        else if (last) post_found(p);
        else walk = WALK_TAIL;
      end else if (last) begin
        post_status(avsh_pkg::ST_TRUNCATED, 0, 0);
      end else begin
        walk      = WALK_SIZE;
        size_acc  = 0;
        size_bad  = 1'b0;
        leb_count = 0;
      end
    endfunction

    function void obu_end(longint unsigned p, bit last);
      if (obu_is_seq) post_found(p);
      else if (last) post_status(avsh_pkg::ST_NOT_FOUND, 0, 0);
      else walk = WALK_HEADER;
    endfunction

    function void walk_byte(bit [7:0] b, bit last, longint unsigned p);
      longint unsigned part;
      longint unsigned sum;
      case (walk)
        WALK_HEADER: begin
          obu_start = p;
          if (b[FORBID_BIT]) begin
            post_status(avsh_pkg::ST_FORBIDDEN, 0, 0);
          end else begin
            obu_is_seq = (b[6:3] == OBU_SEQ_HDR);
            obu_sized  = b[1];
            if (b[2]) begin
              if (last) post_status(avsh_pkg::ST_TRUNCATED, 0, 0);
              else walk = WALK_EXT;
            end else begin
              prefix_end(p, last);
            end
          end
        end
        WALK_EXT: prefix_end(p, last);
        WALK_SIZE: begin
          part = b[6:0];
          part = part << (7 * (leb_count % LEB_MAX_BYTES));
          if (!size_bad) begin
            sum = size_acc + part;
            if (sum > PACKET_LIMIT) size_bad = 1'b1;
            else size_acc = sum;
          end
          leb_count++;
          if (b[LEB_CONT_BIT]) begin
            if (last) post_status(avsh_pkg::ST_TRUNCATED, 0, 0);
            else if (leb_count >= LEB_MAX_BYTES) post_status(avsh_pkg::ST_LEB_LONG, 0, 0);
          end else if (size_bad || p + 1 + size_acc > PACKET_LIMIT) begin
            post_status(avsh_pkg::ST_TRUNCATED, 0, 0);
          end else begin
            payload_left = size_acc;
            if (payload_left == 0) obu_end(p, last);
            else if (last) post_status(avsh_pkg::ST_TRUNCATED, 0, 0);
            else walk = WALK_PAYLOAD;
          end
        end
        WALK_PAYLOAD: begin
          if (payload_left > 0) payload_left--;
          if (payload_left == 0) obu_end(p, last);
          else if (last) post_status(avsh_pkg::ST_TRUNCATED, 0, 0);
        end
        default: begin
          if (last) post_found(p);
        end
      endcase
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      longint unsigned p;
      p = byte_pos;
      if (!decided) begin
        if (p >= PACKET_LIMIT) post_status(avsh_pkg::ST_TOO_LONG, 0, 0);
        else walk_byte(b, last, p);
      end
      if (last) rearm();
      else if (p < PACKET_LIMIT) byte_pos = p + 1;
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      avsh_pkg::result_t got;
      avsh_pkg::result_t want;
      got = beat[$bits(avsh_pkg::result_t)-1:0];
      if (expected_q.size() == 0) begin
        $error("result beat with no packet result pending: status %0d", got.status);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.header_offset !== want.header_offset) begin
        $error("header_offset: expected %0d, got %0d", want.header_offset,
               got.header_offset);
        mismatches++;
      end
      if (got.header_length !== want.header_length) begin
        $error("header_length: expected %0d, got %0d", want.header_length,
               got.header_length);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b1;
  logic [OUT_W-1:0] out_tdata;

  header_search_scoreboard locator_sb = new();

  int unsigned bytes_sent = 0;
  int unsigned stall_pct  = 10;  // receiver back-pressure odds, set per packet
  bit          calm       = 1'b0; // final stretch: no gaps, no stalls

  always #(CLK_HALF) clk = ~clk;

  av1_sequence_header_locator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic bit [7:0] make_header(bit forbid, bit [3:0] kind, bit ext,
                                           bit sized, bit spare);
    return {forbid, kind, ext, sized, spare};
  endfunction

  // leb128 encode, padded with continuation bytes up to nbytes if asked.
  function automatic void push_leb(ref bit [7:0] pkt[$], input longint unsigned value,
                                   input int unsigned nbytes);
    int unsigned need;
    longint unsigned v;
    need = 1;
    v    = value;
    while ((v >> (7 * need)) != 0 && need < 10) need++;
    if (nbytes < need) nbytes = need;
    for (int unsigned i = 0; i < nbytes; i++) begin
      pkt.push_back({i != nbytes - 1, v[6:0]});
      v = v >> 7;
    end
  endfunction

  function automatic void push_junk(ref bit [7:0] pkt[$], input int unsigned n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  // One well-formed OBU with random content; sequence headers are common.
  function automatic void add_obu(ref bit [7:0] pkt[$]);
    bit [3:0]        kind;
    bit              ext;
    bit              sized;
    longint unsigned size;
    kind  = ($urandom_range(0, 9) < 3) ? OBU_SEQ_HDR : 4'($urandom);
    ext   = ($urandom_range(0, 3) == 0);
    sized = ($urandom_range(0, 9) != 0);
    size  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    pkt.push_back(make_header(1'b0, kind, ext, sized, 1'($urandom)));
    if (ext) push_junk(pkt, 1);
    if (sized) begin
      push_leb(pkt, size,
               ($urandom_range(0, 4) == 0) ? $urandom_range(1, LEB_MAX_BYTES) : 1);
      push_junk(pkt, 32'(size));
    end else begin
      push_junk(pkt, $urandom_range(0, 6));
    end
  endfunction

  function automatic void build_packet(ref bit [7:0] pkt[$]);
    int unsigned     roll;
    int unsigned     cut;
    bit              ext;
    longint unsigned huge_size;
    pkt.delete();
    roll = $urandom_range(0, 99);
    ext  = ($urandom_range(0, 3) == 0);
    if (roll >= 95) begin
      // plain noise
      push_junk(pkt, $urandom_range(1, 20));
    end else if (roll >= 90) begin
      // size field that never ends within eight bytes
      pkt.push_back(make_header(1'b0, 4'($urandom), ext, 1'b1, 1'($urandom)));
      if (ext) push_junk(pkt, 1);
      repeat ($urandom_range(LEB_MAX_BYTES, LEB_MAX_BYTES + 2))
        pkt.push_back({1'b1, 7'($urandom)});
      push_junk(pkt, $urandom_range(0, 3));
    end else if (roll >= 85) begin
      // declared size around and past the packet limit
      case ($urandom_range(0, 4))
        0:       huge_size = PACKET_LIMIT;
        1:       huge_size = PACKET_LIMIT - 1;
        2:       huge_size = PACKET_LIMIT - 2;
        3:       huge_size = PACKET_LIMIT + 1;
        default: huge_size = $urandom;
      endcase
      pkt.push_back(make_header(1'b0, 4'($urandom), ext, 1'b1, 1'($urandom)));
      if (ext) push_junk(pkt, 1);
      push_leb(pkt, huge_size, $urandom_range(1, 5));
      push_junk(pkt, $urandom_range(0, 4));
    end else begin
      repeat ($urandom_range(1, 4)) add_obu(pkt);
      if (roll >= 75) begin
        pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
      end else if (roll >= 60 && pkt.size() > 1) begin
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        push_junk(pkt, $urandom_range(1, 5));
      end
    end
  endfunction

  // One byte beat; valid stays up between back-to-back beats.
  task automatic send_byte(input bit [7:0] b, input bit last, input int unsigned gap_pct);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    locator_sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_packet(input bit [7:0] pkt[$], input int unsigned gap_pct);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, gap_pct);
  endtask

  // Hold the sender until every pending packet result has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (locator_sb.expected_q.size() != 0);
  endtask

  // Receiver: check every result beat, stall in random bursts.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) locator_sb.check_result(out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_tready <= 1'b1;
      end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 13);
        out_tready <= 1'b0;
      end
    end
  end

  // Stimulus: directed packets, then random packets, then drain.
  initial begin
    bit [7:0]    pkt[$];
    int unsigned pkt_count;
    int unsigned gap_pct;
    pkt_count = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // forbidden bit, every header bit set
    pkt = '{make_header(1'b1, 4'hF, 1'b1, 1'b1, 1'b1)};
    send_packet(pkt, 0);
    // sized sequence header with zero payload
    pkt = '{make_header(1'b0, OBU_SEQ_HDR, 1'b0, 1'b1, 1'b0), 8'h00};
    send_packet(pkt, 0);
    // extension flagged but the header byte ends the packet
    pkt = '{make_header(1'b0, OBU_SEQ_HDR, 1'b1, 1'b0, 1'b0)};
    send_packet(pkt, 0);
    // sizeless sequence header that is the whole packet
    pkt = '{make_header(1'b0, OBU_SEQ_HDR, 1'b0, 1'b0, 1'b0)};
    send_packet(pkt, 0);
    // sizeless non-header with extension; the rest is swallowed
    pkt = '{make_header(1'b0, OBU_TEMP_DELIM, 1'b1, 1'b0, 1'b0), 8'h00, 8'h55};
    send_packet(pkt, 0);
    // non-header ends exactly at the last byte
    pkt = '{make_header(1'b0, OBU_TEMP_DELIM, 1'b0, 1'b1, 1'b0), 8'h01, 8'hAA};
    send_packet(pkt, 0);
    // size field still continuing at the last byte
    pkt = '{make_header(1'b0, OBU_SEQ_HDR, 1'b0, 1'b1, 1'b0), 8'h85};
    send_packet(pkt, 0);
    // declared size far past the packet limit
    pkt = '{make_header(1'b0, OBU_SEQ_HDR, 1'b0, 1'b1, 1'b0),
            8'hFF, 8'hFF, 8'hFF, 8'h0F};
    send_packet(pkt, 0);
    // empty non-header, then a sequence header with extension, then junk
    pkt = '{make_header(1'b0, OBU_TEMP_DELIM, 1'b0, 1'b1, 1'b0), 8'h00,
            make_header(1'b0, OBU_SEQ_HDR, 1'b1, 1'b1, 1'b0), 8'h80, 8'h00, 8'h7F};
    send_packet(pkt, 0);

    wait_drained();

    while (bytes_sent < BYTE_TARGET) begin
      build_packet(pkt);
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        2:       gap_pct = 30;
        default: gap_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 40;
      endcase
      send_packet(pkt, gap_pct);
      pkt_count++;
      if (pkt_count == 60) wait_drained();
      calm = (bytes_sent >= BYTE_TARGET * 85 / 100);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (locator_sb.mismatches == 0) begin
      $display("av1_sequence_header_locator_top regression: pass");
    end else begin
      $display("av1_sequence_header_locator_top regression: fail");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("av1_sequence_header_locator_top regression: fail");
    $finish;
  end

endmodule
